[sv/tpbo_pkg.sv]
// Shared constants and types for the timed pulse and blink output channel.
package tpbo_pkg;

  localparam int TIME_BITS = 32;
  localparam int PAIR_BITS = 15;
  localparam int TOGGLE_BITS = PAIR_BITS + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_STEADY = 3'd1;
  localparam logic [2:0] CMD_SCHED  = 3'd2;
  localparam logic [2:0] CMD_BLINK  = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;
  localparam logic [1:0] PH_BLINK = 2'd3;

  typedef struct packed {
    logic                 pin_level;
    logic                 active;
    logic [1:0]           phase;
    logic [TIME_BITS-1:0] remaining_ms;
  } result_t;

endpackage

[sv/tpbo_core.sv]
// Channel state and the per-command update that yields one status result.
module tpbo_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [2:0]                          command,
  input  logic                                level,
  input  logic [tpbo_pkg::TIME_BITS-1:0]      delay_ms,
  input  logic [tpbo_pkg::TIME_BITS-1:0]      duration_ms,
  input  logic [tpbo_pkg::PAIR_BITS-1:0]      blink_pairs,
  output tpbo_pkg::result_t                   result
);

  localparam int TB = tpbo_pkg::TIME_BITS;
  localparam int GB = tpbo_pkg::TOGGLE_BITS;

  logic [1:0]    phase_reg, phase_reg_next;
  logic          out_level, out_level_next;
  logic [TB-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [TB-1:0] wait_or_interval, wait_or_interval_next;
  logic [TB-1:0] hold_time, hold_time_next;
  logic [TB-1:0] wait_total, wait_total_next;
  logic          pending_level, pending_level_next;
  logic [GB-1:0] toggles_left, toggles_left_next;
  logic          endless_blink, endless_blink_next;

  logic [TB-1:0]    elapsed_inc;
  logic [GB-1:0]    toggles_dec;
  logic [GB-1:0]    blink_toggles;
  logic [TB+GB-1:0] blink_product;
  logic [TB-1:0]    blink_total;
  logic [TB:0]      sched_sum;
  logic [TB-1:0]    sched_total;
  logic             rem_direct_sel;
  logic [TB-1:0]    rem_direct;
  logic [TB-1:0]    rem_calc;

  always_comb begin
    elapsed_inc = (elapsed_ticks == tpbo_pkg::TMAX) ? elapsed_ticks : elapsed_ticks + 1'b1;
    toggles_dec = (toggles_left != '0) ? toggles_left - 1'b1 : '0;
    blink_toggles = {blink_pairs, 1'b0};
    blink_product = delay_ms * blink_toggles;
    blink_total = (blink_product[TB+GB-1:TB] != '0) ? tpbo_pkg::TMAX : blink_product[TB-1:0];
    sched_sum = {1'b0, delay_ms} + {1'b0, duration_ms};
    sched_total = sched_sum[TB] ? tpbo_pkg::TMAX : sched_sum[TB-1:0];

    phase_reg_next = phase_reg;
    out_level_next = out_level;
    elapsed_ticks_next = elapsed_ticks;
    wait_or_interval_next = wait_or_interval;
    hold_time_next = hold_time;
    wait_total_next = wait_total;
    pending_level_next = pending_level;
    toggles_left_next = toggles_left;
    endless_blink_next = endless_blink;
    rem_direct_sel = 1'b0;
    rem_direct = '0;

    case (command)
      tpbo_pkg::CMD_TICK: begin
        elapsed_ticks_next = elapsed_inc;
        case (phase_reg)
          tpbo_pkg::PH_WAIT: begin
            if (elapsed_inc >= wait_or_interval) begin
              out_level_next = pending_level;
              phase_reg_next = tpbo_pkg::PH_HOLD;
              elapsed_ticks_next = '0;
            end
          end
          tpbo_pkg::PH_HOLD: begin
            if (hold_time != '0 && elapsed_inc >= hold_time) begin
              out_level_next = 1'b0;
              phase_reg_next = tpbo_pkg::PH_IDLE;
            end
          end
          tpbo_pkg::PH_BLINK: begin
            if (wait_or_interval != '0 && elapsed_inc >= wait_or_interval) begin
              out_level_next = ~out_level;
              elapsed_ticks_next = '0;
              if (!endless_blink) begin
                toggles_left_next = toggles_dec;
                if (toggles_dec == '0) begin
                  out_level_next = 1'b0;
                  phase_reg_next = tpbo_pkg::PH_IDLE;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      tpbo_pkg::CMD_STEADY: begin
        out_level_next = level;
        pending_level_next = level;
        phase_reg_next = tpbo_pkg::PH_HOLD;
        elapsed_ticks_next = '0;
        wait_or_interval_next = '0;
        hold_time_next = '0;
        wait_total_next = '0;
      end
      tpbo_pkg::CMD_SCHED: begin
        pending_level_next = level;
        wait_or_interval_next = delay_ms;
        hold_time_next = duration_ms;
        wait_total_next = sched_total;
        elapsed_ticks_next = '0;
        rem_direct_sel = 1'b1;
        if (delay_ms == '0) begin
          out_level_next = level;
          phase_reg_next = tpbo_pkg::PH_HOLD;
          rem_direct = duration_ms;
        end else begin
          phase_reg_next = tpbo_pkg::PH_WAIT;
          rem_direct = (duration_ms == '0) ? '0 : sched_total;
        end
      end
      tpbo_pkg::CMD_BLINK: begin
        out_level_next = 1'b0;
        phase_reg_next = tpbo_pkg::PH_BLINK;
        elapsed_ticks_next = '0;
        wait_or_interval_next = delay_ms;
        endless_blink_next = (blink_pairs == '0);
        toggles_left_next = blink_toggles;
        hold_time_next = (blink_pairs == '0) ? '0 : blink_total;
        rem_direct_sel = 1'b1;
        rem_direct = (blink_pairs == '0) ? '0 : blink_total;
      end
      tpbo_pkg::CMD_STOP: begin
        out_level_next = 1'b0;
        phase_reg_next = tpbo_pkg::PH_IDLE;
      end
      default: begin
      end
    endcase

    if (phase_reg_next == tpbo_pkg::PH_IDLE || hold_time_next == '0) begin
      rem_calc = '0;
    end else if (phase_reg_next == tpbo_pkg::PH_WAIT) begin
      rem_calc = (wait_total_next > elapsed_ticks_next) ?
                 wait_total_next - elapsed_ticks_next : '0;
    end else begin
      rem_calc = (hold_time_next > elapsed_ticks_next) ?
                 hold_time_next - elapsed_ticks_next : '0;
    end

    result.pin_level = out_level_next;
    result.active = (phase_reg_next != tpbo_pkg::PH_IDLE);
    result.phase = phase_reg_next;
    result.remaining_ms = rem_direct_sel ? rem_direct : rem_calc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg <= tpbo_pkg::PH_IDLE;
      out_level <= 1'b0;
      elapsed_ticks <= '0;
      wait_or_interval <= '0;
      hold_time <= '0;
      wait_total <= '0;
      pending_level <= 1'b0;
      toggles_left <= '0;
      endless_blink <= 1'b0;
    end else if (step) begin
      phase_reg <= phase_reg_next;
      out_level <= out_level_next;
      elapsed_ticks <= elapsed_ticks_next;
      wait_or_interval <= wait_or_interval_next;
      hold_time <= hold_time_next;
      wait_total <= wait_total_next;
      pending_level <= pending_level_next;
      toggles_left <= toggles_left_next;
      endless_blink <= endless_blink_next;
    end
  end

endmodule

[sv/timed_pulse_blink_output.sv]
// Top level of the timed pulse and blink output channel with its result register.
// Each input transfer is one command (tick, steady level, scheduled level, blink or
// stop) and yields exactly one status transfer carrying the pin level, active flag,
// phase and remaining time. A command is applied to the channel state in the cycle
// it is taken and its status is held in an output register, so one command is
// accepted every clock cycle as long as the status side keeps taking results;
// the status appears in the cycle after the command is taken.
module timed_pulse_blink_output (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          command,
  input  logic                                level,
  input  logic [tpbo_pkg::TIME_BITS-1:0]      delay_ms,
  input  logic [tpbo_pkg::TIME_BITS-1:0]      duration_ms,
  input  logic [tpbo_pkg::PAIR_BITS-1:0]      blink_pairs,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                pin_level,
  output logic                                active,
  output logic [1:0]                          phase,
  output logic [tpbo_pkg::TIME_BITS-1:0]      remaining_ms
);

  logic              take;
  tpbo_pkg::result_t result;
  tpbo_pkg::result_t res_reg;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  tpbo_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (take),
    .command     (command),
    .level       (level),
    .delay_ms    (delay_ms),
    .duration_ms (duration_ms),
    .blink_pairs (blink_pairs),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_reg <= result;
    end
  end

  assign pin_level = res_reg.pin_level;
  assign active = res_reg.active;
  assign phase = res_reg.phase;
  assign remaining_ms = res_reg.remaining_ms;

endmodule

[tb/timed_pulse_blink_output_test.sv]
// Self-checking testbench for the timed pulse and blink output channel.
module timed_pulse_blink_output_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = tpbo_pkg::TIME_BITS;
  localparam int PW = tpbo_pkg::PAIR_BITS;
  localparam int GW = tpbo_pkg::TOGGLE_BITS;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam int unsigned RANDOM_COMMANDS = 880;
  localparam int unsigned PRESSURE_AT = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam logic [TW-1:0] ONES = {TW{1'b1}};
  localparam logic [PW-1:0] PAIRS_MAX = {PW{1'b1}};

  typedef struct {
    logic [2:0]          cmd;
    logic                lvl;
    logic [TW-1:0]       dly;
    logic [TW-1:0]       dur;
    logic [PW-1:0]       pairs;
    bit                  typed;
    tpbo_pkg::result_t   status;
  } command_row_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [2:0]    command = tpbo_pkg::CMD_TICK;
  logic          level = 1'b0;
  logic [TW-1:0] delay_ms = '0;
  logic [TW-1:0] duration_ms = '0;
  logic [PW-1:0] blink_pairs = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          pin_level;
  logic          active;
  logic [1:0]    phase;
  logic [TW-1:0] remaining_ms;

  bit                cur_typed = 1'b0;
  tpbo_pkg::result_t cur_status = '0;

  logic [1:0]    ch_phase;
  logic          ch_pin;
  logic [TW-1:0] ch_elapsed;
  logic [TW-1:0] ch_interval;
  logic [TW-1:0] ch_hold;
  logic          ch_pending;
  logic [GW-1:0] ch_toggles;
  logic          ch_endless;

  tpbo_pkg::result_t expected_status[$];
  tpbo_pkg::result_t predicted;
  tpbo_pkg::result_t observed;
  command_row_t      directed[$];
  int unsigned       errors = 0;
  int unsigned       n_kind[8];
  int unsigned       n_checked = 0;
  int unsigned       n_commands = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       longest_stall = 0;
  bit                moved;

  timed_pulse_blink_output DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .level(level),
    .delay_ms(delay_ms),
    .duration_ms(duration_ms),
    .blink_pairs(blink_pairs),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pin_level(pin_level),
    .active(active),
    .phase(phase),
    .remaining_ms(remaining_ms)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void enter_idle();
    ch_pin = 1'b0;
    ch_phase = tpbo_pkg::PH_IDLE;
  endfunction

  function automatic void advance_tick();
    if (ch_elapsed != tpbo_pkg::TMAX) ch_elapsed = ch_elapsed + 1'b1;
    case (ch_phase)
      tpbo_pkg::PH_WAIT: begin
        if (ch_elapsed >= ch_interval) begin
          ch_pin = ch_pending;
          ch_phase = tpbo_pkg::PH_HOLD;
          ch_elapsed = '0;
        end
      end
      tpbo_pkg::PH_HOLD: begin
        if (ch_hold != 0 && ch_elapsed >= ch_hold) enter_idle();
      end
      tpbo_pkg::PH_BLINK: begin
        if (ch_interval != 0 && ch_elapsed >= ch_interval) begin
          ch_pin = ~ch_pin;
          ch_elapsed = '0;
          if (!ch_endless) begin
            if (ch_toggles != 0) ch_toggles = ch_toggles - 1'b1;
            if (ch_toggles == 0) enter_idle();
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [TW-1:0] time_left();
    logic [63:0] sum;
    logic [63:0] left;
    left = '0;
    if (ch_phase == tpbo_pkg::PH_IDLE || ch_hold == 0) begin
      left = '0;
    end else if (ch_phase == tpbo_pkg::PH_WAIT) begin
      sum = 64'(ch_interval) + 64'(ch_hold);
      if (sum > 64'(tpbo_pkg::TMAX)) sum = 64'(tpbo_pkg::TMAX);
      left = (sum > 64'(ch_elapsed)) ? sum - 64'(ch_elapsed) : 64'd0;
    end else begin
      left = (ch_hold > ch_elapsed) ? 64'(ch_hold - ch_elapsed) : 64'd0;
    end
    return (left > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : left[31:0];
  endfunction

  function automatic tpbo_pkg::result_t apply_command(logic [2:0] c, logic l, logic [TW-1:0] d,
                                                      logic [TW-1:0] u, logic [PW-1:0] p);
    tpbo_pkg::result_t status;
    logic [63:0]       total;
    case (c)
      tpbo_pkg::CMD_TICK: advance_tick();
      tpbo_pkg::CMD_STEADY: begin
        ch_pin = l;
        ch_pending = l;
        ch_phase = tpbo_pkg::PH_HOLD;
        ch_elapsed = '0;
        ch_interval = '0;
        ch_hold = '0;
      end
      tpbo_pkg::CMD_SCHED: begin
        ch_pending = l;
        ch_interval = d;
        ch_hold = u;
        ch_elapsed = '0;
        if (d == 0) begin
          ch_pin = l;
          ch_phase = tpbo_pkg::PH_HOLD;
        end else begin
          ch_phase = tpbo_pkg::PH_WAIT;
        end
      end
      tpbo_pkg::CMD_BLINK: begin
        ch_pin = 1'b0;
        ch_phase = tpbo_pkg::PH_BLINK;
        ch_elapsed = '0;
        ch_interval = d;
        ch_endless = (p == 0);
        ch_toggles = {p, 1'b0};
        if (p == 0) begin
          ch_hold = '0;
        end else begin
          total = 64'(d) * 64'({p, 1'b0});
          ch_hold = (total > 64'(tpbo_pkg::TMAX)) ? tpbo_pkg::TMAX : total[TW-1:0];
        end
      end
      tpbo_pkg::CMD_STOP: enter_idle();
      default: ;
    endcase
    status.pin_level = ch_pin;
    status.active = (ch_phase != tpbo_pkg::PH_IDLE);
    status.phase = ch_phase;
    status.remaining_ms = time_left();
    return status;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [TW-1:0] pick_time(int unsigned small_max);
    if ($urandom_range(99, 0) < 85) return $urandom_range(small_max, 0);
    return $urandom();
  endfunction

  function automatic command_row_t row(logic [2:0] c, logic l, logic [TW-1:0] d,
                                       logic [TW-1:0] u, logic [PW-1:0] p,
                                       bit k, logic pin, logic act, logic [1:0] ph,
                                       logic [TW-1:0] rem);
    command_row_t r;
    r.cmd = c;
    r.lvl = l;
    r.dly = d;
    r.dur = u;
    r.pairs = p;
    r.typed = k;
    r.status = '{pin, act, ph, rem};
    return r;
  endfunction

  task automatic send(input logic [2:0] c, input logic l, input logic [TW-1:0] d,
                      input logic [TW-1:0] u, input logic [PW-1:0] p,
                      input bit k, input tpbo_pkg::result_t s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    level <= l;
    delay_ms <= d;
    duration_ms <= u;
    blink_pairs <= p;
    cur_typed <= k;
    cur_status <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick();
    send(tpbo_pkg::CMD_TICK, 1'($urandom()), $urandom(), $urandom(), PW'($urandom()), 1'b0,
         '0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        predicted = apply_command(command, level, delay_ms, duration_ms, blink_pairs);
        expected_status.push_back(cur_typed ? cur_status : predicted);
        n_kind[command]++;
        n_commands++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t ns: status transfer with no command waiting for it", $time);
        end else begin
          observed = expected_status.pop_front();
          compare_field("pin_level", 32'(observed.pin_level), 32'(pin_level));
          compare_field("active", 32'(observed.active), 32'(active));
          compare_field("phase", 32'(observed.phase), 32'(phase));
          compare_field("remaining_ms", 32'(observed.remaining_ms), 32'(remaining_ms));
          n_checked++;
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles > longest_stall) longest_stall = stall_cycles;
      end
      if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t ns: no transfer for %0d cycles", $time, stall_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    bit          pressure_done;
    int unsigned gap;
    pressure_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && n_commands >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (($urandom_range(9, 0) == 0) ? 100 : $urandom_range(30, 1)) @(posedge clk);
        gap = pick_gap();
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned   useful;
    int unsigned   ticks;
    int unsigned   r;
    logic [2:0]    lead;
    logic [PW-1:0] pairs;

    ch_phase = tpbo_pkg::PH_IDLE;
    ch_pin = 1'b0;
    ch_elapsed = '0;
    ch_interval = '0;
    ch_hold = '0;
    ch_pending = 1'b0;
    ch_toggles = '0;
    ch_endless = 1'b0;
    foreach (n_kind[i]) n_kind[i] = 0;

    directed.push_back(row(tpbo_pkg::CMD_STOP, 1'b0, '0, '0, '0,
                           1'b1, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    directed.push_back(row(tpbo_pkg::CMD_TICK, 1'b1, ONES, ONES, PAIRS_MAX,
                           1'b1, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    directed.push_back(row(CMD_UNUSED_HI, 1'b1, ONES, ONES, PAIRS_MAX,
                           1'b1, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    directed.push_back(row(tpbo_pkg::CMD_STEADY, 1'b1, ONES, ONES, PAIRS_MAX,
                           1'b1, 1'b1, 1'b1, tpbo_pkg::PH_HOLD, '0));
    directed.push_back(row(tpbo_pkg::CMD_TICK, 1'b0, '0, '0, '0,
                           1'b1, 1'b1, 1'b1, tpbo_pkg::PH_HOLD, '0));
    directed.push_back(row(tpbo_pkg::CMD_STEADY, 1'b0, '0, '0, '0,
                           1'b1, 1'b0, 1'b1, tpbo_pkg::PH_HOLD, '0));
    directed.push_back(row(tpbo_pkg::CMD_SCHED, 1'b1, '0, ONES, '0,
                           1'b1, 1'b1, 1'b1, tpbo_pkg::PH_HOLD, ONES));
    directed.push_back(row(tpbo_pkg::CMD_TICK, 1'b0, '0, '0, '0,
                           1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    directed.push_back(row(tpbo_pkg::CMD_SCHED, 1'b0, ONES, ONES, '0,
                           1'b1, 1'b1, 1'b1, tpbo_pkg::PH_WAIT, ONES));
    directed.push_back(row(tpbo_pkg::CMD_STOP, 1'b1, ONES, ONES, PAIRS_MAX,
                           1'b1, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    directed.push_back(row(tpbo_pkg::CMD_SCHED, 1'b1, 32'd2, 32'd2, '0,
                           1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    repeat (4) directed.push_back(row(tpbo_pkg::CMD_TICK, 1'b0, '0, '0, '0,
                                      1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    directed.push_back(row(tpbo_pkg::CMD_BLINK, 1'b0, 32'd1, '0, 15'd1,
                           1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    repeat (2) directed.push_back(row(tpbo_pkg::CMD_TICK, 1'b0, '0, '0, '0,
                                      1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    directed.push_back(row(tpbo_pkg::CMD_BLINK, 1'b0, '0, '0, 15'd3,
                           1'b1, 1'b0, 1'b1, tpbo_pkg::PH_BLINK, '0));
    directed.push_back(row(tpbo_pkg::CMD_TICK, 1'b0, '0, '0, '0,
                           1'b1, 1'b0, 1'b1, tpbo_pkg::PH_BLINK, '0));
    directed.push_back(row(tpbo_pkg::CMD_BLINK, 1'b0, ONES, '0, PAIRS_MAX,
                           1'b1, 1'b0, 1'b1, tpbo_pkg::PH_BLINK, ONES));
    directed.push_back(row(tpbo_pkg::CMD_BLINK, 1'b0, 32'd2, '0, '0,
                           1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    repeat (3) directed.push_back(row(tpbo_pkg::CMD_TICK, 1'b0, '0, '0, '0,
                                      1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    directed.push_back(row(tpbo_pkg::CMD_SCHED, 1'b1, 32'd3, '0, '0,
                           1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));
    repeat (4) directed.push_back(row(tpbo_pkg::CMD_TICK, 1'b0, '0, '0, '0,
                                      1'b0, 1'b0, 1'b0, tpbo_pkg::PH_IDLE, '0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send(directed[i].cmd, directed[i].lvl, directed[i].dly, directed[i].dur,
           directed[i].pairs, directed[i].typed, directed[i].status);

    // Each episode sends a lead command, mostly a timed activity, then ticks with some noise.
    useful = 0;
    while (useful < RANDOM_COMMANDS) begin
      r = $urandom_range(99, 0);
      if (r < 15) lead = tpbo_pkg::CMD_STEADY;
      else if (r < 50) lead = tpbo_pkg::CMD_SCHED;
      else if (r < 85) lead = tpbo_pkg::CMD_BLINK;
      else if (r < 93) lead = tpbo_pkg::CMD_STOP;
      else lead = tpbo_pkg::CMD_TICK;
      pairs = ($urandom_range(9, 0) == 0) ? PW'($urandom()) : PW'($urandom_range(4, 0));
      send(lead, 1'($urandom()), pick_time((lead == tpbo_pkg::CMD_BLINK) ? 4 : 6),
           pick_time(6), pairs, 1'b0, '0);
      useful++;
      ticks = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 0);
      repeat (ticks) begin
        r = $urandom_range(99, 0);
        if (r < 3) begin
          send(3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)), 1'($urandom()), $urandom(),
               $urandom(), PW'($urandom()), 1'b0, '0);
        end else begin
          if (r < 5) send(tpbo_pkg::CMD_STOP, 1'($urandom()), $urandom(), $urandom(),
                          PW'($urandom()), 1'b0, '0);
          else send_tick();
          useful++;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_status.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected status transfers never arrived", $time,
               expected_status.size());
    end

    $display("Sent %0d ticks, %0d steady, %0d scheduled, %0d blink, %0d stop, %0d unknown.",
             n_kind[tpbo_pkg::CMD_TICK], n_kind[tpbo_pkg::CMD_STEADY],
             n_kind[tpbo_pkg::CMD_SCHED], n_kind[tpbo_pkg::CMD_BLINK],
             n_kind[tpbo_pkg::CMD_STOP],
             n_commands - n_kind[tpbo_pkg::CMD_TICK] - n_kind[tpbo_pkg::CMD_STEADY]
             - n_kind[tpbo_pkg::CMD_SCHED] - n_kind[tpbo_pkg::CMD_BLINK]
             - n_kind[tpbo_pkg::CMD_STOP]);
    $display("Checked %0d status transfers; longest stretch without a transfer %0d cycles.",
             n_checked, longest_stall);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
